/* sv/wmc_pkg.sv */
// Shared types, codes and helpers for the watch mode controller.
// No dependencies; imported by every module of the block.
package wmc_pkg;

   // Default saturation point of the stopwatch, in whole minutes.
   localparam int DEFAULT_MAX_MINUTES = 99;

   // Reset value of the alarm blink window, in seconds.
   localparam logic [5:0] BLINK_RESET = 6'd4;

   // Request kinds.
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Button codes carried by a frame request.
   localparam logic [2:0] BTN_NONE   = 3'd0;
   localparam logic [2:0] BTN_FACE   = 3'd1;
   localparam logic [2:0] BTN_EDIT   = 3'd2;
   localparam logic [2:0] BTN_INC    = 3'd3;
   localparam logic [2:0] BTN_SELECT = 3'd4;

   // Face codes.
   localparam logic [1:0] FACE_CLOCK     = 2'd0;
   localparam logic [1:0] FACE_ALARM     = 2'd1;
   localparam logic [1:0] FACE_STOPWATCH = 2'd2;

   // Field select codes.
   localparam logic [1:0] FIELD_HOUR   = 2'd0;
   localparam logic [1:0] FIELD_MINUTE = 2'd1;
   localparam logic [1:0] FIELD_SECOND = 2'd2;

   // One input request.
   typedef struct packed {
      logic       cmd;
      logic [2:0] button;
      logic [4:0] rtc_hour;
      logic [5:0] rtc_minute;
      logic [5:0] rtc_second;
   } wmc_req_type;

   // One result.
   typedef struct packed {
      logic [1:0] face;
      logic       edit_mode;
      logic [1:0] edit_field;
      logic       alarm_on;
      logic       alarm_led;
      logic       user_led;
      logic       invert_display;
      logic [6:0] show_a;
      logic [5:0] show_b;
      logic [6:0] show_c;
      logic       rtc_write;
   } wmc_rsp_type;

   // Controls from the face logic to the stopwatch counter.
   typedef struct packed {
      logic step;         // a request is being processed this cycle
      logic tick;         // the request is a centisecond tick
      logic toggle_run;   // start or stop
      logic clear_entry;  // face has just moved from alarm to stopwatch
      logic stop_clear;   // increment on the stopwatch face: stop and zero
   } wmc_sw_ctrl_type;

   // Hour plus one, wrapping at 24; inputs up to 31 are tolerated.
   function automatic logic [4:0] wrap_hour(input logic [4:0] value);
      logic [5:0] sum;
      sum = {1'b0, value} + 6'd1;
      if (sum >= 6'd24) begin
         sum = sum - 6'd24;
      end
      return sum[4:0];
   endfunction

   // Minute or second plus one, wrapping at 60; inputs up to 63 are tolerated.
   function automatic logic [5:0] wrap_sixty(input logic [5:0] value);
      logic [6:0] sum;
      sum = {1'b0, value} + 7'd1;
      if (sum >= 7'd60) begin
         sum = sum - 7'd60;
      end
      return sum[5:0];
   endfunction

endpackage

/* sv/watch_mode_controller.sv */
// Top level of the watch mode controller: request register, face and edit
// logic, result register. Depends on wmc_pkg and wmc_stopwatch.
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_stall  wmc_req_type
//   rsp_         out         rsp_valid/rsp_stall  wmc_rsp_type
//   csr_         in          csr_write            6-bit blink window
//
// The face logic runs from the request register straight into the result
// register. One request per cycle is sustained while the result side does
// not stall. A stalled result holds; the request register still takes one
// more request. Synchronous reset clears the valid flags and the watch state
// but sets the user LED; the blink window returns to 4 seconds.
module watch_mode_controller #(
   parameter int MAX_MINUTES = wmc_pkg::DEFAULT_MAX_MINUTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  wmc_pkg::wmc_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wmc_pkg::wmc_rsp_type rsp_payload,
   input  logic                 csr_write,
   input  logic [5:0]           csr_data
);
   import wmc_pkg::*;

   localparam int MinW = $clog2(MAX_MINUTES + 1);

   // Handshake and pipeline registers.
   logic            req_valid_ff;
   wmc_req_type     req_ff;
   logic            rsp_valid_ff;
   wmc_rsp_type     rsp_ff, rsp_in;
   logic            move;
   logic            accept;

   // Configuration.
   logic [5:0]      blink_ff;

   // Watch state.
   logic [1:0]      face_ff, face_in;
   logic            edit_ff, edit_in;
   logic [1:0]      field_ff, field_in;
   logic            inc_ff, inc_in;
   logic            alarm_en_ff, alarm_en_in;
   logic [4:0]      alarm_hour_ff, alarm_hour_in;
   logic [5:0]      alarm_min_ff, alarm_min_in;
   logic [4:0]      edit_hour_ff, edit_hour_in;
   logic [5:0]      edit_min_ff, edit_min_in;
   logic [5:0]      edit_sec_ff, edit_sec_in;
   logic [1:0]      prev_face_ff, prev_face_in;
   logic            prev_edit_ff, prev_edit_in;
   logic            alarm_led_ff, alarm_led_in;
   logic            user_led_ff, user_led_in;
   logic            invert_ff, invert_in;

   // Stopwatch link.
   wmc_sw_ctrl_type   sw_ctrl;
   logic [MinW - 1:0] sw_min;
   logic [5:0]        sw_sec;
   logic [6:0]        sw_cs;
   logic [MinW + 6:0] sw_min_ext;

   // The request register moves on whenever the result register is free.
   assign move      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sw_min_ext = {7'd0, sw_min};

   wmc_stopwatch #(
      .MAX_MINUTES(MAX_MINUTES)
   ) u_stopwatch (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sw_ctrl),
      .view_min (sw_min),
      .view_sec (sw_sec),
      .view_cs  (sw_cs)
   );

   // Face, edit, alarm and LED logic for the request in the request register.
   always_comb begin
      face_in       = face_ff;
      edit_in       = edit_ff;
      field_in      = field_ff;
      inc_in        = inc_ff;
      alarm_en_in   = alarm_en_ff;
      alarm_hour_in = alarm_hour_ff;
      alarm_min_in  = alarm_min_ff;
      edit_hour_in  = edit_hour_ff;
      edit_min_in   = edit_min_ff;
      edit_sec_in   = edit_sec_ff;
      prev_face_in  = prev_face_ff;
      prev_edit_in  = prev_edit_ff;
      alarm_led_in  = alarm_led_ff;
      user_led_in   = user_led_ff;
      invert_in     = invert_ff;
      sw_ctrl       = '0;
      sw_ctrl.step  = move;
      sw_ctrl.tick  = (req_ff.cmd == CMD_TICK);
      rsp_in        = '0;

      if (req_ff.cmd == CMD_FRAME) begin
         // Apply the button.
         case (req_ff.button)
            BTN_FACE: begin
               face_in  = (face_ff >= FACE_STOPWATCH) ? FACE_CLOCK : face_ff + 2'd1;
               edit_in  = 1'b0;
               field_in = FIELD_HOUR;
            end
            BTN_EDIT: begin
               field_in = FIELD_HOUR;
               if (face_ff == FACE_ALARM) begin
                  alarm_en_in = !alarm_en_ff;
               end else if (face_ff == FACE_STOPWATCH) begin
                  sw_ctrl.toggle_run = 1'b1;
               end else if (face_ff == FACE_CLOCK) begin
                  edit_in = !edit_ff;
               end
            end
            BTN_INC: begin
               inc_in = !inc_ff;
               if (face_ff == FACE_CLOCK && !edit_ff) begin
                  user_led_in = !user_led_ff;
               end
            end
            BTN_SELECT: begin
               if (face_ff != FACE_STOPWATCH) begin
                  field_in = (field_ff >= FIELD_SECOND) ? FIELD_HOUR : field_ff + 2'd1;
                  if (face_ff == FACE_CLOCK && !edit_ff) begin
                     invert_in = !invert_ff;
                  end
               end
            end
            default: begin
            end
         endcase

         // Alarm match: blink on even seconds inside the window.
         if (alarm_en_in && alarm_hour_ff == req_ff.rtc_hour &&
             alarm_min_ff == req_ff.rtc_minute && req_ff.rtc_second < blink_ff) begin
            alarm_led_in = !req_ff.rtc_second[0];
         end

         // Leaving clock edit commits the edited time.
         rsp_in.rtc_write = (prev_face_ff == FACE_CLOCK) && prev_edit_ff &&
                            (face_in != FACE_CLOCK || !edit_in);

         sw_ctrl.clear_entry = (prev_face_ff == FACE_ALARM) && (face_in == FACE_STOPWATCH);

         // Entering clock edit loads the current time.
         if (face_in == FACE_CLOCK && edit_in && !prev_edit_ff) begin
            edit_hour_in = req_ff.rtc_hour;
            edit_min_in  = req_ff.rtc_minute;
            edit_sec_in  = req_ff.rtc_second;
         end
      end

      // Display, from the values before this request's increment.
      case (face_in)
         FACE_CLOCK: begin
            if (edit_in) begin
               rsp_in.show_a = {2'd0, edit_hour_in};
               rsp_in.show_b = edit_min_in;
               rsp_in.show_c = {1'b0, edit_sec_in};
            end else begin
               rsp_in.show_a = {2'd0, req_ff.rtc_hour};
               rsp_in.show_b = req_ff.rtc_minute;
               rsp_in.show_c = {1'b0, req_ff.rtc_second};
            end
         end
         FACE_ALARM: begin
            rsp_in.show_a = {2'd0, alarm_hour_ff};
            rsp_in.show_b = alarm_min_ff;
            rsp_in.show_c = 7'd0;
         end
         FACE_STOPWATCH: begin
            rsp_in.show_a = sw_min_ext[6:0];
            rsp_in.show_b = sw_sec;
            rsp_in.show_c = sw_cs;
         end
         default: begin
            rsp_in.show_a = 7'd0;
            rsp_in.show_b = 6'd0;
            rsp_in.show_c = 7'd0;
         end
      endcase

      if (rsp_in.rtc_write) begin
         rsp_in.show_a = {2'd0, edit_hour_in};
         rsp_in.show_b = edit_min_in;
         rsp_in.show_c = {1'b0, edit_sec_in};
      end

      if (req_ff.cmd == CMD_FRAME) begin
         // Pending increment on the face now shown.
         if (face_in == FACE_CLOCK) begin
            if (edit_in && inc_in) begin
               case (field_in)
                  FIELD_HOUR: begin
                     edit_hour_in = wrap_hour(edit_hour_in);
                     inc_in       = 1'b0;
                  end
                  FIELD_MINUTE: begin
                     edit_min_in = wrap_sixty(edit_min_in);
                     inc_in      = 1'b0;
                  end
                  FIELD_SECOND: begin
                     edit_sec_in = wrap_sixty(edit_sec_in);
                     inc_in      = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end else if (face_in == FACE_ALARM) begin
            if (inc_in) begin
               case (field_in)
                  FIELD_HOUR: begin
                     alarm_hour_in = wrap_hour(alarm_hour_ff);
                     inc_in        = 1'b0;
                  end
                  FIELD_MINUTE: begin
                     alarm_min_in = wrap_sixty(alarm_min_ff);
                     inc_in       = 1'b0;
                  end
                  FIELD_SECOND: begin
                     alarm_hour_in = wrap_hour(alarm_hour_ff);
                     inc_in        = 1'b0;
                     field_in      = FIELD_HOUR;
                  end
                  default: begin
                  end
               endcase
            end
         end else if (face_in == FACE_STOPWATCH) begin
            if (inc_in) begin
               sw_ctrl.stop_clear = 1'b1;
               inc_in             = 1'b0;
            end
         end

         prev_face_in = face_in;
         prev_edit_in = edit_in;
      end

      rsp_in.face           = face_in;
      rsp_in.edit_mode      = edit_in;
      rsp_in.edit_field     = field_in;
      rsp_in.alarm_on       = alarm_en_in;
      rsp_in.alarm_led      = alarm_led_in;
      rsp_in.user_led       = user_led_in;
      rsp_in.invert_display = invert_in;
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (accept) begin
         req_valid_ff <= 1'b1;
      end else if (move) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_ff <= rsp_in;
      end
   end

   // Blink window register.
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_ff <= BLINK_RESET;
      end else if (csr_write) begin
         blink_ff <= csr_data;
      end
   end

   // Watch state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         face_ff       <= FACE_CLOCK;
         edit_ff       <= 1'b0;
         field_ff      <= FIELD_HOUR;
         inc_ff        <= 1'b0;
         alarm_en_ff   <= 1'b0;
         alarm_hour_ff <= 5'd0;
         alarm_min_ff  <= 6'd0;
         edit_hour_ff  <= 5'd0;
         edit_min_ff   <= 6'd0;
         edit_sec_ff   <= 6'd0;
         prev_face_ff  <= FACE_CLOCK;
         prev_edit_ff  <= 1'b0;
         alarm_led_ff  <= 1'b0;
         user_led_ff   <= 1'b1;
         invert_ff     <= 1'b0;
      end else if (move) begin
         face_ff       <= face_in;
         edit_ff       <= edit_in;
         field_ff      <= field_in;
         inc_ff        <= inc_in;
         alarm_en_ff   <= alarm_en_in;
         alarm_hour_ff <= alarm_hour_in;
         alarm_min_ff  <= alarm_min_in;
         edit_hour_ff  <= edit_hour_in;
         edit_min_ff   <= edit_min_in;
         edit_sec_ff   <= edit_sec_in;
         prev_face_ff  <= prev_face_in;
         prev_edit_ff  <= prev_edit_in;
         alarm_led_ff  <= alarm_led_in;
         user_led_ff   <= user_led_in;
         invert_ff     <= invert_in;
      end
   end

   // Edit mode exists only on the clock face.
   assert property (@(posedge clock) disable iff (reset)
      edit_ff |-> face_ff == FACE_CLOCK)
      else $error("edit mode active away from the clock face");

   // A held request is neither lost nor altered while the result side stalls.
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !move |=> req_valid_ff && $stable(req_ff))
      else $error("held request changed while stalled");

   // A commit is reported only once clock editing has ended.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rtc_write |->
         (rsp_ff.face != FACE_CLOCK) || !rsp_ff.edit_mode)
      else $error("time commit reported while still editing");

   // Stopwatch display digits stay within their ranges.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.face == FACE_STOPWATCH && !rsp_ff.rtc_write |->
         (rsp_ff.show_b < 6'd60) && (rsp_ff.show_c < 7'd100))
      else $error("stopwatch digits out of range");

endmodule

/* sv/wmc_stopwatch.sv */
// Stopwatch counter of the watch mode controller, kept as minutes,
// seconds and centiseconds. Depends on wmc_pkg.
module wmc_stopwatch #(
   parameter int MAX_MINUTES = wmc_pkg::DEFAULT_MAX_MINUTES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wmc_pkg::wmc_sw_ctrl_type              ctrl,
   output logic [$clog2(MAX_MINUTES + 1) - 1:0]  view_min,
   output logic [5:0]                            view_sec,
   output logic [6:0]                            view_cs
);
   import wmc_pkg::*;

   localparam int MinW = $clog2(MAX_MINUTES + 1);
   localparam logic [MinW - 1:0] MaxMin = MinW'(MAX_MINUTES);

   logic              run_ff, run_in;
   logic [MinW - 1:0] min_ff, min_in, min_inc;
   logic [5:0]        sec_ff, sec_in, sec_inc;
   logic [6:0]        cs_ff, cs_in, cs_inc;
   logic              saturated;

   // The count stops at the maximum minutes, 59 seconds and 99 centiseconds.
   assign saturated = (min_ff == MaxMin) && (sec_ff == 6'd59) && (cs_ff == 7'd99);

   // Mixed-radix increment by one centisecond.
   always_comb begin
      min_inc = min_ff;
      sec_inc = sec_ff;
      cs_inc  = cs_ff + 7'd1;
      if (cs_ff == 7'd99) begin
         cs_inc  = 7'd0;
         sec_inc = sec_ff + 6'd1;
         if (sec_ff == 6'd59) begin
            sec_inc = 6'd0;
            min_inc = min_ff + MinW'(1);
         end
      end
   end

   // Shown value and next value for the request in hand.
   always_comb begin
      run_in   = run_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      cs_in    = cs_ff;
      view_min = min_ff;
      view_sec = sec_ff;
      view_cs  = cs_ff;
      if (ctrl.tick) begin
         if (run_ff && !saturated) begin
            min_in = min_inc;
            sec_in = sec_inc;
            cs_in  = cs_inc;
         end
         view_min = min_in;
         view_sec = sec_in;
         view_cs  = cs_in;
      end else begin
         run_in = run_ff ^ ctrl.toggle_run;
         if (ctrl.clear_entry) begin
            min_in = '0;
            sec_in = 6'd0;
            cs_in  = 7'd0;
         end
         view_min = min_in;
         view_sec = sec_in;
         view_cs  = cs_in;
         if (ctrl.stop_clear) begin
            run_in = 1'b0;
            min_in = '0;
            sec_in = 6'd0;
            cs_in  = 7'd0;
         end
      end
   end

   // Counter registers advance only when a request is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         min_ff <= '0;
         sec_ff <= 6'd0;
         cs_ff  <= 7'd0;
      end else if (ctrl.step) begin
         run_ff <= run_in;
         min_ff <= min_in;
         sec_ff <= sec_in;
         cs_ff  <= cs_in;
      end
   end

endmodule
